// ===== rtl/core/cpts_pkg.sv =====
// Shared types, codes and constants of the counter/priority task scheduler.
`default_nettype none

package cpts_pkg;

    // Default number of task table entries.
    localparam int TASK_SLOTS_DEF = 64;

    // Operation codes carried in the input request.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_YIELD = 3'd1;
    localparam logic [2:0] OP_PDIS  = 3'd2;
    localparam logic [2:0] OP_PEN   = 3'd3;
    localparam logic [2:0] OP_WRITE = 3'd4;

    // Counter value at which a decrement saturates.
    localparam logic [15:0] CNT_MIN = 16'h8000;

    // One task table entry as held in memory.
    typedef struct packed {
        logic        present;
        logic        runnable;
        logic [15:0] counter;   // two's complement slice counter
        logic [7:0]  prio;
        logic [7:0]  depth;     // preempt disable depth
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Entry 0 after reset: present, runnable, priority one.
    localparam t_entry ENTRY0_RST = '{present: 1'b1, runnable: 1'b1, counter: 16'h0000,
                                      prio: 8'd1, depth: 8'd0};

endpackage

`default_nettype wire

// ===== rtl/core/cpts_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module cpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/counter_priority_task_scheduler.sv =====
// Top level of the counter/priority task scheduler: sequencer around the task table memory.
`default_nettype none

// The block keeps a table of TASK_SLOTS tasks (present and runnable marks, a signed
// 16-bit slice counter, an 8-bit priority and an 8-bit preempt depth) in one
// synchronous RAM, plus the index of the current task. Each request on the slave
// stream carries one operation in tuser: tick, yield, preempt disable, preempt enable
// or write task entry; every request yields exactly one result on the master stream.
// A tick that drains the current counter (with preemption enabled) and a yield both
// reschedule: the table is scanned one entry per cycle for the runnable task with the
// largest non-negative counter, lowest index winning ties, and task 0 when none is
// runnable. If the best counter is zero, a second pass rewrites every present entry's
// counter to half of itself plus its priority and searches again in the same sweep;
// if the best is still zero, that pick stands and the starved flag is raised.
// A request that does not reschedule only works on one entry before its result; a
// reschedule scans the table once, and twice with the refill pass, through the
// single RAM read port visiting one entry per cycle. Table entries carry a valid
// bit each, so reset takes effect at once with no clearing pass. A new request is
// taken while the previous result still waits on the master side.
module counter_priority_task_scheduler #(
    parameter int TASK_SLOTS = cpts_pkg::TASK_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // tdata, from bit 0: task_index[5:0], task_present[6], task_runnable[7],
    // task_priority[15:8].
    input  wire logic [15:0] i_s_tdata,
    // tuser, from bit 0: operation[2:0].
    input  wire logic [2:0]  i_s_tuser,
    // Result stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // tdata, from bit 0: current_task[5:0], previous_task[11:6], switched[12],
    // starved[13], zero fill[15:14].
    output logic      [15:0] o_m_tdata
);

    localparam int AW = $clog2(TASK_SLOTS);
    localparam int CW = $clog2(TASK_SLOTS + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MOD    = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DECIDE = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Latched request.
    logic [2:0]    r_op;
    logic [5:0]    r_idx;
    logic          r_present;
    logic          r_runnable;
    logic [7:0]    r_prio;
    logic [AW-1:0] r_maddr;

    // Scheduler state.
    logic [AW-1:0] r_cur;
    logic [AW-1:0] r_prev;
    logic          r_starved;
    logic          r_second;

    // Scan pipeline.
    logic [CW-1:0]    r_ptr;
    logic             r_q_vld;
    logic [AW-1:0]    r_q_addr;
    logic [15:0]      r_best;
    logic [AW-1:0]    r_pick;
    logic [TASK_SLOTS-1:0] r_valid;

    // Output register.
    logic        r_out_valid;
    logic [15:0] r_out_data;

    // Memory ports.
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    cpts_pkg::t_entry       ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [cpts_pkg::ENTRY_W-1:0] ram_rdata;

    cpts_pkg::t_entry q_ent;
    logic             accept;
    logic             idx_ok;
    logic             issue;
    logic             keep_run;
    logic [15:0]      dec_cnt;
    logic [15:0]      refill_cnt;
    logic [15:0]      cand_cnt;
    logic             cand_win;
    logic             scan_last;
    logic             out_load;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign idx_ok = ({3'b000, r_idx} < 9'(TASK_SLOTS));
    assign issue  = (r_state == S_SCAN) && (r_ptr < CW'(TASK_SLOTS));

    // An entry never written since reset reads as its reset value.
    always_comb begin
        if (r_valid[r_q_addr]) begin
            q_ent = cpts_pkg::t_entry'(ram_rdata);
        end else if (r_q_addr == '0) begin
            q_ent = cpts_pkg::ENTRY0_RST;
        end else begin
            q_ent = '0;
        end
    end

    // Tick arithmetic on the current entry; the decrement saturates at the low end.
    assign dec_cnt  = (q_ent.counter == cpts_pkg::CNT_MIN) ? q_ent.counter
                                                          : q_ent.counter - 16'd1;
    assign keep_run = ($signed(dec_cnt) > 16'sd0) || (q_ent.depth != 8'd0);

    // Refill value: arithmetic half of the counter plus the priority.
    assign refill_cnt = {q_ent.counter[15], q_ent.counter[15:1]} + {8'd0, q_ent.prio};
    assign cand_cnt   = r_second ? refill_cnt : q_ent.counter;
    assign cand_win   = r_q_vld && q_ent.present && q_ent.runnable
                        && ($signed(cand_cnt) > $signed(r_best));
    assign scan_last  = r_q_vld && (r_ptr == CW'(TASK_SLOTS));

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    // Read address: the entry the request touches, or the scan pointer.
    always_comb begin
        if (r_state == S_IDLE) begin
            if (i_s_tuser == cpts_pkg::OP_WRITE) begin
                ram_raddr = AW'(i_s_tdata[5:0]);
            end else begin
                ram_raddr = r_cur;
            end
        end else if (issue) begin
            ram_raddr = r_ptr[AW-1:0];
        end else begin
            ram_raddr = r_cur;
        end
    end

    // Write port: read-modify-write of one entry, or the refill write-back.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_maddr;
        ram_wdata = q_ent;
        if (r_state == S_MOD) begin
            case (r_op)
                cpts_pkg::OP_TICK: begin
                    ram_we            = 1'b1;
                    ram_wdata.counter = keep_run ? dec_cnt : 16'd0;
                end
                cpts_pkg::OP_YIELD: begin
                    ram_we            = 1'b1;
                    ram_wdata.counter = 16'd0;
                end
                cpts_pkg::OP_PDIS: begin
                    ram_we = (q_ent.depth != 8'hFF);
                    ram_wdata.depth = q_ent.depth + 8'd1;
                end
                cpts_pkg::OP_PEN: begin
                    ram_we = (q_ent.depth != 8'd0);
                    ram_wdata.depth = q_ent.depth - 8'd1;
                end
                cpts_pkg::OP_WRITE: begin
                    ram_we             = idx_ok;
                    ram_wdata.present  = r_present;
                    ram_wdata.runnable = r_runnable;
                    ram_wdata.prio     = r_prio;
                    ram_wdata.counter  = {8'd0, r_prio};
                end
                default: begin
                    ram_we = 1'b0;
                end
            endcase
        end else if ((r_state == S_SCAN) && r_second && r_q_vld && q_ent.present) begin
            ram_we            = 1'b1;
            ram_waddr         = r_q_addr;
            ram_wdata.counter = refill_cnt;
        end
    end

    cpts_ram #(
        .WIDTH(cpts_pkg::ENTRY_W),
        .DEPTH(TASK_SLOTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if ((r_op == cpts_pkg::OP_YIELD)
                    || ((r_op == cpts_pkg::OP_TICK) && !keep_run)) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!r_second && (r_best == 16'd0)) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_q_vld     <= 1'b0;
            r_second    <= 1'b0;
            r_starved   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_q_vld <= issue;
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (accept) begin
                r_second  <= 1'b0;
                r_starved <= 1'b0;
            end
            if (r_state == S_DECIDE) begin
                if (!r_second && (r_best == 16'd0)) begin
                    r_second <= 1'b1;
                end else begin
                    r_cur     <= r_pick;
                    r_starved <= r_second && (r_best == 16'd0);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_q_addr <= ram_raddr;
        if (accept) begin
            r_op       <= i_s_tuser;
            r_idx      <= i_s_tdata[5:0];
            r_present  <= i_s_tdata[6];
            r_runnable <= i_s_tdata[7];
            r_prio     <= i_s_tdata[15:8];
            r_maddr    <= ram_raddr;
            r_prev     <= r_cur;
        end
        // Each search pass starts from an empty best and task 0.
        if ((r_state == S_MOD) || (r_state == S_DECIDE)) begin
            r_ptr  <= '0;
            r_best <= 16'hFFFF;
            r_pick <= '0;
        end else if (r_state == S_SCAN) begin
            if (issue) begin
                r_ptr <= r_ptr + CW'(1);
            end
            if (cand_win) begin
                r_best <= cand_cnt;
                r_pick <= r_q_addr;
            end
        end
        if (out_load) begin
            r_out_data <= {2'b00, r_starved, (r_cur != r_prev), 6'(r_prev), 6'(r_cur)};
        end
    end

endmodule

`default_nettype wire
